// ----- sv/bpd_pkg.sv -----
// Package for the bounded priority dispatcher: sizes, codes, beat structs
// and the controller/datapath command and status groups. No dependencies.
package bpd_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int LIM_W       = 5;
    localparam int CMP_W       = (CNT_W > LIM_W) ? CNT_W : LIM_W;
    localparam int MAX_STARTS  = 16;
    localparam int START_W     = $clog2(MAX_STARTS + 1);

    typedef enum logic [2:0] {
        OP_ADD      = 3'd0,
        OP_CANCEL   = 3'd1,
        OP_CHPRIO   = 3'd2,
        OP_COMPLETE = 3'd3,
        OP_DISPATCH = 3'd4
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_CANCEL = 2'd2
    } t_phase;

    typedef enum logic [0:0] {
        KIND_STATUS = 1'b0,
        KIND_START  = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OP,
        S_CHECK,
        S_SCAN,
        S_EVAL,
        S_START,
        S_STATUS
    } t_state;

    localparam logic [0:0] CFG_LIMIT = 1'b0;

    typedef struct packed {
        logic [2:0]         command;
        logic [31:0]        request_id;
        logic signed [15:0] priority_req;
    } t_cmd_in;

    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [31:0] started_id;
        logic        last;
    } t_result;

    typedef struct packed {
        logic load;
        logic do_op;
        logic scan_clr;
        logic scan_step;
        logic do_start;
        logic do_status;
    } t_dp_ctl;

    typedef struct packed {
        logic want_dispatch;
        logic can_dispatch;
        logic scan_last;
        logic best_ok;
    } t_dp_sts;

endpackage

// ----- sv/bpd_ctrl.sv -----
// Controller state machine of the dispatcher: sequences command, scan and
// start steps. Depends on bpd_pkg.
module bpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  bpd_pkg::t_dp_sts  i_sts,
    output bpd_pkg::t_dp_ctl  o_ctl,
    output logic              o_busy
);

    bpd_pkg::t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bpd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            bpd_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = bpd_pkg::S_OP;
                end
            end
            bpd_pkg::S_OP: begin
                o_ctl.do_op = 1'b1;
                n_state = i_sts.want_dispatch ? bpd_pkg::S_CHECK : bpd_pkg::S_STATUS;
            end
            bpd_pkg::S_CHECK: begin
                o_ctl.scan_clr = 1'b1;
                n_state = i_sts.can_dispatch ? bpd_pkg::S_SCAN : bpd_pkg::S_STATUS;
            end
            bpd_pkg::S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = bpd_pkg::S_EVAL;
                end
            end
            bpd_pkg::S_EVAL: begin
                n_state = i_sts.best_ok ? bpd_pkg::S_START : bpd_pkg::S_STATUS;
            end
            bpd_pkg::S_START: begin
                o_ctl.do_start = 1'b1;
                n_state = bpd_pkg::S_CHECK;
            end
            bpd_pkg::S_STATUS: begin
                o_ctl.do_status = 1'b1;
                n_state = bpd_pkg::S_IDLE;
            end
            default: begin
                n_state = bpd_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/bpd_datapath.sv -----
// Datapath of the dispatcher: request table, active count, scan unit and
// result register. Depends on bpd_pkg.
module bpd_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  bpd_pkg::t_cmd_in           i_cmd,
    input  logic [bpd_pkg::LIM_W-1:0]  i_limit,
    input  bpd_pkg::t_dp_ctl           i_ctl,
    output bpd_pkg::t_dp_sts           o_sts,
    output bpd_pkg::t_result           o_result,
    output logic                       o_result_valid
);

    localparam int D = bpd_pkg::TABLE_DEPTH;

    // table, contiguous prefix of r_fill entries
    logic [31:0]        r_id    [D];
    logic signed [15:0] r_prio  [D];
    bpd_pkg::t_phase    r_phase [D];
    logic [bpd_pkg::CNT_W-1:0]   r_fill;
    logic [bpd_pkg::LIM_W-1:0]   r_cnt;
    logic [bpd_pkg::START_W-1:0] r_started;

    bpd_pkg::t_cmd_in   r_cmd;
    bpd_pkg::t_status   r_status;

    // scan unit
    logic [bpd_pkg::IDX_W-1:0] r_scan;
    logic [bpd_pkg::IDX_W-1:0] r_best;
    logic signed [15:0]        r_best_key;
    logic                      r_best_ok;

    bpd_pkg::t_result r_res;
    logic             r_res_vld;

    // id matching: newest hit and oldest hit
    logic                      found_new, found_old, new_wait;
    logic [bpd_pkg::IDX_W-1:0] pos_new, pos_old, drop_pos;
    logic                      drop_en;
    logic [bpd_pkg::CNT_W-1:0] fill_m1;
    logic [bpd_pkg::CMP_W-1:0] fill_x, cnt_x, lim_x;
    bpd_pkg::t_opcode          opc;

    assign opc = bpd_pkg::t_opcode'(r_cmd.command);

    always_comb begin
        found_new = 1'b0;
        found_old = 1'b0;
        new_wait  = 1'b0;
        pos_new   = '0;
        pos_old   = '0;
        for (int k = 0; k < D; k++) begin
            if (k < int'(r_fill) && r_id[k] == r_cmd.request_id) begin
                found_new = 1'b1;
                pos_new   = bpd_pkg::IDX_W'(k);
                new_wait  = (r_phase[k] == bpd_pkg::PH_WAIT);
            end
        end
        for (int k = D - 1; k >= 0; k--) begin
            if (k < int'(r_fill) && r_id[k] == r_cmd.request_id) begin
                found_old = 1'b1;
                pos_old   = bpd_pkg::IDX_W'(k);
            end
        end
    end

    assign drop_en  = i_ctl.do_op &&
                      ((opc == bpd_pkg::OP_CANCEL && found_new && new_wait) ||
                       (opc == bpd_pkg::OP_COMPLETE && found_old));
    assign drop_pos = (opc == bpd_pkg::OP_CANCEL) ? pos_new : pos_old;

    // status toward the controller
    assign fill_m1 = r_fill - 1'b1;
    assign fill_x  = bpd_pkg::CMP_W'(r_fill);
    assign cnt_x   = bpd_pkg::CMP_W'(r_cnt);
    assign lim_x   = bpd_pkg::CMP_W'(i_limit);

    always_comb begin
        o_sts.want_dispatch = (opc == bpd_pkg::OP_CANCEL) ||
                              (opc == bpd_pkg::OP_COMPLETE) ||
                              (opc == bpd_pkg::OP_DISPATCH);
        o_sts.can_dispatch  = (r_started < bpd_pkg::START_W'(bpd_pkg::MAX_STARTS)) &&
                              (cnt_x < lim_x) && (fill_x > cnt_x);
        o_sts.scan_last     = (r_scan == fill_m1[bpd_pkg::IDX_W-1:0]);
        o_sts.best_ok       = r_best_ok;
    end

    // table storage
    always_ff @(posedge i_clk) begin
        if (i_ctl.do_op) begin
            unique case (opc)
                bpd_pkg::OP_ADD: begin
                    if (int'(r_fill) < D) begin
                        r_id[r_fill[bpd_pkg::IDX_W-1:0]]    <= r_cmd.request_id;
                        r_prio[r_fill[bpd_pkg::IDX_W-1:0]]  <= r_cmd.priority_req;
                        r_phase[r_fill[bpd_pkg::IDX_W-1:0]] <= bpd_pkg::PH_WAIT;
                    end
                end
                bpd_pkg::OP_CANCEL: begin
                    if (found_new && !new_wait) begin
                        r_phase[pos_new] <= bpd_pkg::PH_CANCEL;
                    end
                end
                bpd_pkg::OP_CHPRIO: begin
                    if (found_old) begin
                        r_prio[pos_old] <= r_cmd.priority_req;
                    end
                end
                default: begin
                end
            endcase
        end
        // close the gap on removal
        if (drop_en) begin
            for (int k = 0; k < D - 1; k++) begin
                if (k >= int'(drop_pos)) begin
                    r_id[k]    <= r_id[k+1];
                    r_prio[k]  <= r_prio[k+1];
                    r_phase[k] <= r_phase[k+1];
                end
            end
        end
        if (i_ctl.do_start) begin
            r_phase[r_best] <= bpd_pkg::PH_ACTIVE;
        end
    end

    // fill and active counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_ctl.do_op && opc == bpd_pkg::OP_ADD && int'(r_fill) < D) begin
                r_fill <= r_fill + 1'b1;
            end else if (drop_en) begin
                r_fill <= r_fill - 1'b1;
            end
            if (i_ctl.do_op && opc == bpd_pkg::OP_COMPLETE && r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
            end else if (i_ctl.do_start) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // command capture, status code, start count
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd     <= i_cmd;
            r_started <= '0;
        end
        if (i_ctl.do_start) begin
            r_started <= r_started + 1'b1;
        end
        if (i_ctl.do_op) begin
            unique case (opc)
                bpd_pkg::OP_ADD:
                    r_status <= (int'(r_fill) < D) ? bpd_pkg::ST_OK : bpd_pkg::ST_FULL;
                bpd_pkg::OP_CANCEL:
                    r_status <= found_new ? bpd_pkg::ST_OK : bpd_pkg::ST_NOTFOUND;
                bpd_pkg::OP_CHPRIO, bpd_pkg::OP_COMPLETE:
                    r_status <= found_old ? bpd_pkg::ST_OK : bpd_pkg::ST_NOTFOUND;
                default:
                    r_status <= bpd_pkg::ST_OK;
            endcase
        end
    end

    // serial best search, one entry a cycle, earliest wins ties
    always_ff @(posedge i_clk) begin
        if (i_ctl.scan_clr) begin
            r_scan    <= '0;
            r_best_ok <= 1'b0;
        end else if (i_ctl.scan_step) begin
            r_scan <= r_scan + 1'b1;
            if (r_phase[r_scan] == bpd_pkg::PH_WAIT &&
                (!r_best_ok || r_prio[r_scan] > r_best_key)) begin
                r_best_ok  <= 1'b1;
                r_best     <= r_scan;
                r_best_key <= r_prio[r_scan];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_vld <= 1'b0;
        end else begin
            r_res_vld <= i_ctl.do_start || i_ctl.do_status;
        end
        if (i_ctl.do_start) begin
            r_res.kind       <= bpd_pkg::KIND_START;
            r_res.status     <= bpd_pkg::ST_OK;
            r_res.started_id <= r_id[r_best];
            r_res.last       <= 1'b0;
        end else if (i_ctl.do_status) begin
            r_res.kind       <= bpd_pkg::KIND_STATUS;
            r_res.status     <= r_status;
            r_res.started_id <= r_cmd.request_id;
            r_res.last       <= 1'b1;
        end
    end

    assign o_result       = r_res;
    assign o_result_valid = r_res_vld;

endmodule

// ----- sv/bounded_priority_dispatcher_top.sv -----
// Top level of the bounded priority dispatcher: APB limit register,
// controller and datapath. Depends on bpd_pkg, bpd_ctrl, bpd_datapath.
//
//  channel   ports                            handshake
//  command   i_cmd                            start & !busy
//  result    o_result                         o_result_valid, one cycle
//  config    psel penable pwrite paddr ...    APB, pready tied high
//
// A command without dispatch goes from the op step to the status step. A dispatch
// pass adds a check step per check; a passing check adds a serial priority scan
// of every filled table entry, an evaluate step and, per start, a start step.
// busy stays high until the status beat is issued; that beat appears on the
// cycle after, with the block already idle.
// Reset is synchronous, active low; it empties the table and zeroes the
// active count, and sets the limit to 2. Results cannot be stalled.
module bounded_priority_dispatcher_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  bpd_pkg::t_cmd_in i_cmd,
    output bpd_pkg::t_result o_result,
    output logic             o_result_valid,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [bpd_pkg::LIM_W-1:0] r_limit;
    bpd_pkg::t_dp_ctl ctl;
    bpd_pkg::t_dp_sts sts;

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= bpd_pkg::LIM_W'(2);
        end else if (psel && penable && pwrite && paddr[2] == bpd_pkg::CFG_LIMIT) begin
            r_limit <= pwdata[bpd_pkg::LIM_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == bpd_pkg::CFG_LIMIT) ? 32'(r_limit) : 32'd0;

    bpd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    bpd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_limit        (r_limit),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

`ifndef ASSERT_OFF
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");
    a_start_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.kind) |->
        (o_result.status == bpd_pkg::ST_OK && !o_result.last))
        else $error("start beat with bad status or last");
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.kind) |-> (o_result.last && !busy))
        else $error("status beat not final or block still busy");
`endif

endmodule
